// ===== hdl/sequence_slot_table_assert.svh =====
// assertion macros for the sequence slot table
`ifndef SEQUENCE_SLOT_TABLE_ASSERT_SVH
`define SEQUENCE_SLOT_TABLE_ASSERT_SVH

`ifndef SYNTH

`define SST_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sequence_slot_table: same-cycle check failed");

`define SST_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sequence_slot_table: next-cycle check failed");

`else

`define SST_ASSERT_IMP(label, clk, rst, ante, cons)

`define SST_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/sst_pkg.sv =====
package sst_pkg;

   localparam int SEQ_W      = 32;
   localparam int FUNC_W     = 1;
   localparam int SLOT_IDX_W = 4;

   localparam int DEFAULT_WINDOW_SLOTS = 16;

   localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_CLAIM  = 1'b1;

endpackage

// ===== hdl/sst_req_if.sv =====
interface sst_req_if;

   logic                       valid;
   logic                       ready;
   logic [sst_pkg::FUNC_W-1:0] func;
   logic [sst_pkg::SEQ_W-1:0]  seq_value;

   modport source (output valid, output func, output seq_value, input ready);
   modport sink   (input valid, input func, input seq_value, output ready);

endinterface

// ===== hdl/sst_rsp_if.sv =====
interface sst_rsp_if;

   logic                           valid;
   logic                           ready;
   logic                           found;
   logic [sst_pkg::SLOT_IDX_W-1:0] slot_index;

   modport source (output valid, output found, output slot_index, input ready);
   modport sink   (input valid, input found, input slot_index, output ready);

endinterface

// ===== hdl/sequence_slot_table.sv =====
// channel   dir  handshake     payload
// req_chan  in   valid/ready   func, seq_value
// rsp_chan  out  valid/ready   found, slot_index
//
// the block takes no new item until the current one is finished; the spacing between
// accepts is set by the single tag memory read port that the scan walks one slot per cycle.
// the result is registered in S_FINISH once rsp_chan can take it; a claim writes
// its tag back in that same cycle.
// synchronous reset clears all slot valid bits, so every tag reads as zero.
// a stalled rsp_chan holds the finished item in the scan's last state;
// req_chan is taken only while the sequencer is idle.
`include "sequence_slot_table_assert.svh"

module sequence_slot_table #(
   parameter int WINDOW_SLOTS = sst_pkg::DEFAULT_WINDOW_SLOTS
) (
   input  logic      clock,
   input  logic      reset,
   sst_req_if.sink   req_chan,
   sst_rsp_if.source rsp_chan
);
   import sst_pkg::*;

   localparam int IDX_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(WINDOW_SLOTS - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_FINISH
   } state_type;

   state_type               state_ff, state_in;
   logic [FUNC_W-1:0]       func_ff, func_in;
   logic [SEQ_W-1:0]        seq_ff, seq_in;
   logic [IDX_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic                    cmp_en_ff, cmp_en_in;
   logic [IDX_W-1:0]        cmp_idx_ff, cmp_idx_in;
   logic [SEQ_W-1:0]        rd_data_ff;
   logic                    rd_vld_ff;
   logic                    hit_ff, hit_in;
   logic [IDX_W-1:0]        best_idx_ff, best_idx_in;
   logic [SEQ_W-1:0]        best_tag_ff, best_tag_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [SLOT_IDX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [WINDOW_SLOTS-1:0] valid_ff, valid_in;

   logic [SEQ_W-1:0]        slot_tags_ff [WINDOW_SLOTS];

   logic                    req_fire;
   logic                    finish_fire;
   logic                    tag_write;
   logic [SEQ_W-1:0]        cur_tag;
   logic [IDX_W+SLOT_IDX_W-1:0] idx_ext;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && (state_ff == S_IDLE);
   assign finish_fire    = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_chan.ready);
   assign tag_write      = finish_fire && (func_ff == FUNC_CLAIM);

   // a slot never written since reset reads as zero
   assign cur_tag = rd_vld_ff ? rd_data_ff : '0;
   assign idx_ext = {{SLOT_IDX_W{1'b0}}, best_idx_ff};

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.found      = rsp_found_ff;
   assign rsp_chan.slot_index = rsp_index_ff;

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      seq_in       = seq_ff;
      rd_ptr_in    = rd_ptr_ff;
      cmp_en_in    = (state_ff == S_SCAN);
      cmp_idx_in   = rd_ptr_ff;
      hit_in       = hit_ff;
      best_idx_in  = best_idx_ff;
      best_tag_in  = best_tag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_found_in = rsp_found_ff;
      rsp_index_in = rsp_index_ff;
      valid_in     = valid_ff;

      // shared compare unit, one slot per cycle
      if (cmp_en_ff) begin
         if (func_ff == FUNC_CLAIM) begin
            if ((cmp_idx_ff == '0) || (cur_tag < best_tag_ff)) begin
               best_idx_in = cmp_idx_ff;
               best_tag_in = cur_tag;
            end
         end else if (!hit_ff && (cur_tag == seq_ff)) begin
            hit_in      = 1'b1;
            best_idx_in = cmp_idx_ff;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               func_in     = req_chan.func;
               seq_in      = req_chan.seq_value;
               rd_ptr_in   = '0;
               hit_in      = 1'b0;
               best_idx_in = '0;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            if (rd_ptr_ff == LAST_SLOT) begin
               state_in = S_DRAIN;
            end else begin
               rd_ptr_in = rd_ptr_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (finish_fire) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = (func_ff == FUNC_CLAIM) || hit_ff;
               rsp_index_in = ((func_ff == FUNC_CLAIM) || hit_ff) ?
                              idx_ext[SLOT_IDX_W-1:0] : '0;
               if (tag_write) begin
                  valid_in[best_idx_ff] = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cmp_en_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         cmp_en_ff    <= cmp_en_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
      end
      func_ff      <= func_in;
      seq_ff       <= seq_in;
      rd_ptr_ff    <= rd_ptr_in;
      cmp_idx_ff   <= cmp_idx_in;
      best_idx_ff  <= best_idx_in;
      best_tag_ff  <= best_tag_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
   end

   // tag memory: one read port for the scan, one write port for a claim
   always_ff @(posedge clock) begin
      rd_data_ff <= slot_tags_ff[rd_ptr_ff];
      rd_vld_ff  <= valid_ff[rd_ptr_ff];
      if (tag_write) begin
         slot_tags_ff[best_idx_ff] <= seq_ff;
      end
   end

   `SST_ASSERT_NXT(a_accept_starts_scan, clock, reset, req_fire,
      (state_ff == S_SCAN) && (rd_ptr_ff == '0))
   `SST_ASSERT_NXT(a_scan_ends_at_last, clock, reset,
      (state_ff == S_SCAN) && (rd_ptr_ff == LAST_SLOT), state_ff == S_DRAIN)
   `SST_ASSERT_NXT(a_claim_found, clock, reset, tag_write,
      rsp_valid_ff && rsp_found_ff && valid_ff[$past(best_idx_ff)])
   `SST_ASSERT_IMP(a_miss_index_zero, clock, reset, rsp_valid_ff && !rsp_found_ff,
      rsp_index_ff == '0)

endmodule

// ===== tb/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sst_pkg::*;

   localparam int SLOTS        = DEFAULT_WINDOW_SLOTS;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = SLOTS + 24;
   localparam int PHASE_ITEMS  = 250;
   localparam int HOLD_CYCLES  = 300;

   typedef logic [SEQ_W-1:0]      seq_type;
   typedef logic [FUNC_W-1:0]     func_type;
   typedef logic [SLOT_IDX_W-1:0] idx_type;

   typedef struct packed {
      logic    found;
      idx_type slot_index;
   } slot_result_type;

   class slot_tag_scoreboard;
      seq_type         slot_tags [SLOTS];
      slot_result_type expected_q [$];
      int              mismatches;

      function new();
         foreach (slot_tags[i]) slot_tags[i] = '0;
         mismatches = 0;
      endfunction

      // predicts the table update and the result for one accepted item
      function void note_request(func_type func, seq_type seq);
         slot_result_type want;
         int              best;
         want = '0;
         if (func == FUNC_CLAIM) begin
            best = 0;
            for (int i = 1; i < SLOTS; i++) begin
               if (slot_tags[i] < slot_tags[best]) best = i;
            end
            slot_tags[best] = seq;
            want.found = 1'b1;
            want.slot_index = SLOT_IDX_W'(best);
         end else begin
            for (int i = 0; i < SLOTS; i++) begin
               if (!want.found && slot_tags[i] == seq) begin
                  want.found = 1'b1;
                  want.slot_index = SLOT_IDX_W'(i);
               end
            end
         end
         expected_q.push_back(want);
      endfunction

      function void check_response(logic found, idx_type slot_index);
         slot_result_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            $display("%0t: result expected none actual found=%0b slot_index=%0d", $time,
                     found, slot_index);
            return;
         end
         want = expected_q.pop_front();
         if (want.found !== found) begin
            mismatches++;
            $display("%0t: found expected %0b actual %0b", $time, want.found, found);
         end
         if (want.slot_index !== slot_index) begin
            mismatches++;
            $display("%0t: slot_index expected %0d actual %0d", $time, want.slot_index,
                     slot_index);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   sst_req_if req_bus ();
   sst_rsp_if rsp_bus ();

   sequence_slot_table u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   slot_tag_scoreboard sb;

   int      sender_gap_pct = 0;
   int      recv_stall_pct = 0;
   int      hold_left      = 0;
   int      cycle_count    = 0;
   seq_type next_seq_num   = 32'd100;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // result side: check on handshake, then pick next ready
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            sb.check_response(rsp_bus.found, rsp_bus.slot_index);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic offer_item(input func_type func, input seq_type seq);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.func      <= func;
      req_bus.seq_value <= seq;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      sb.note_request(func, seq);
   endtask

   // mostly lookups of live tags and claims of rising sequence numbers
   task automatic pick_random_item(output func_type func, output seq_type seq);
      int r;
      r = $urandom_range(99);
      if (r < 40) begin
         func = FUNC_LOOKUP;
         seq  = sb.slot_tags[$urandom_range(SLOTS-1)];
      end else if (r < 55) begin
         func = FUNC_LOOKUP;
         seq  = seq_type'($urandom_range(40));
      end else if (r < 65) begin
         func = FUNC_LOOKUP;
         seq  = $urandom();
      end else if (r < 80) begin
         func = FUNC_CLAIM;
         next_seq_num = next_seq_num + seq_type'($urandom_range(3, 1));
         seq  = next_seq_num;
      end else if (r < 90) begin
         func = FUNC_CLAIM;
         seq  = $urandom();
      end else begin
         func = FUNC_CLAIM;
         case ($urandom_range(2))
            0:       seq = '0;
            1:       seq = '1;
            default: seq = sb.slot_tags[$urandom_range(SLOTS-1)];
         endcase
      end
   endtask

   task automatic run_phase(input int gap_pct, input int stall_pct, input int count);
      func_type func;
      seq_type  seq;
      sender_gap_pct = gap_pct;
      recv_stall_pct = stall_pct;
      repeat (count) begin
         pick_random_item(func, seq);
         offer_item(func, seq);
      end
   endtask

   initial begin
      sb = new();
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.func      <= FUNC_LOOKUP;
      req_bus.seq_value <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // fresh table: zero hits slot zero, then misses at both ends of the range
      offer_item(FUNC_LOOKUP, 32'd0);
      offer_item(FUNC_LOOKUP, 32'd1);
      offer_item(FUNC_LOOKUP, 32'hFFFF_FFFF);
      offer_item(FUNC_CLAIM, 32'd7);
      offer_item(FUNC_LOOKUP, 32'd7);
      offer_item(FUNC_LOOKUP, 32'd0);
      // fill every slot with the maximum tag, then all ties go to slot zero
      repeat (SLOTS) offer_item(FUNC_CLAIM, 32'hFFFF_FFFF);
      offer_item(FUNC_CLAIM, 32'd5);
      offer_item(FUNC_LOOKUP, 32'd5);
      offer_item(FUNC_LOOKUP, 32'hFFFF_FFFF);

      run_phase(0, 0, PHASE_ITEMS);
      run_phase(53, 0, PHASE_ITEMS);
      run_phase(0, 53, PHASE_ITEMS);
      run_phase(6, 6, PHASE_ITEMS);

      // long receiver hold while items keep coming
      hold_left = HOLD_CYCLES;
      run_phase(0, 0, 50);

      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
